/* rtl/core/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared constants and types for the fraction arithmetic core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

  localparam int WordWidth = 32;
  localparam int MagWidth  = 64;

  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdSub = 3'd1;
  localparam logic [2:0] CmdMul = 3'd2;
  localparam logic [2:0] CmdDiv = 3'd3;
  localparam logic [2:0] CmdCmp = 3'd4;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrDivZero  = 2'd1;
  localparam logic [1:0] ErrOverflow = 2'd2;
  localparam logic [1:0] ErrZeroDen  = 2'd3;

  typedef logic [MagWidth-1:0] mag_t;

  // Request to the shared divider.
  typedef struct packed {
    logic start;
    mag_t dividend;
    mag_t divisor;
  } div_req_t;

  // Reply from the shared divider.
  typedef struct packed {
    logic done;
    mag_t quotient;
    mag_t remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/rau_div.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring divider on 64-bit magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t      rsp
);
  import rau_pkg::*;

  localparam int CntWidth = $clog2(MagWidth + 1);

  logic                busy_r, busy_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  mag_t                quo_r, quo_nxt;
  mag_t                rem_r, rem_nxt;
  mag_t                dsr_r, dsr_nxt;
  logic                done_r, done_nxt;
  logic [MagWidth:0]   trial;
  logic [MagWidth:0]   shifted;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[MagWidth-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntWidth'(MagWidth);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[MagWidth]) begin
        rem_nxt = trial[MagWidth-1:0];
        quo_nxt = {quo_r[MagWidth-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[MagWidth-1:0];
        quo_nxt = {quo_r[MagWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

/* rtl/core/rau_seq.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit sequencer
// Steps one operation through gcd, divide and multiply phases on the
// shared divider and a single 32x32 multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [2:0]            cmd,
  input  wire logic [31:0]           lhs_num,
  input  wire logic [31:0]           lhs_den,
  input  wire logic [31:0]           rhs_num,
  input  wire logic [31:0]           rhs_den,
  output rau_pkg::div_req_t          dreq,
  input  wire rau_pkg::div_rsp_t     drsp,
  output logic                       done,
  output logic [31:0]                res_num,
  output logic [31:0]                res_den,
  output logic                       equal,
  output logic [1:0]                 error
);
  import rau_pkg::*;

  // States.
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StGcdDiv = 4'd1;
  localparam logic [3:0] StGcdWt  = 4'd2;
  localparam logic [3:0] StRedA   = 4'd3;
  localparam logic [3:0] StRedAWt = 4'd4;
  localparam logic [3:0] StRedB   = 4'd5;
  localparam logic [3:0] StRedBWt = 4'd6;
  localparam logic [3:0] StMul    = 4'd7;
  localparam logic [3:0] StFinish = 4'd8;
  localparam logic [3:0] StDone   = 4'd9;

  // Phases: what the current reduce or gcd serves.
  localparam logic [2:0] PhLeft  = 3'd0;
  localparam logic [2:0] PhRight = 3'd1;
  localparam logic [2:0] PhLcm   = 3'd2;
  localparam logic [2:0] PhLcmQ  = 3'd3;
  localparam logic [2:0] PhRes   = 3'd4;

  // Multiply steps.
  localparam logic [2:0] MuA = 3'd0;
  localparam logic [2:0] MuB = 3'd1;
  localparam logic [2:0] MuC = 3'd2;
  localparam logic [2:0] MuD = 3'd3;

  logic [3:0] st_r, st_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic [2:0] mu_r, mu_nxt;
  logic [2:0] cmd_r, cmd_nxt;

  logic ln_s_r, ld_s_r, rn_s_r, rd_s_r, n_s_r, d_s_r;
  logic ln_s_nxt, ld_s_nxt, rn_s_nxt, rd_s_nxt, n_s_nxt, d_s_nxt;
  mag_t ln_r, ld_r, rn_r, rd_r, n_r, d_r;
  mag_t ln_nxt, ld_nxt, rn_nxt, rd_nxt, n_nxt, d_nxt;
  mag_t ga_r, gb_r, ga_nxt, gb_nxt, g_r, g_nxt;
  mag_t lf_r, rf_r, lf_nxt, rf_nxt;
  mag_t t1_r, t1_nxt;
  logic t1_s_r, t1_s_nxt;
  logic eq_r, eq_nxt;
  logic [1:0] err_r, err_nxt;
  logic [31:0] rn_out_r, rd_out_r, rn_out_nxt, rd_out_nxt;

  div_req_t dreq_c;
  logic [31:0] ma, mb;
  mag_t mp;
  mag_t lim;
  logic fit_n, fit_d;

  function automatic mag_t absw(input logic [31:0] v);
    absw = v[31] ? mag_t'(32'(-v)) | (v == 32'h8000_0000 ? mag_t'(32'h8000_0000) : '0)
                 : mag_t'(v);
  endfunction

  function automatic logic [31:0] enc(input logic s, input mag_t m);
    enc = s ? 32'(-m[31:0]) : m[31:0];
  endfunction

  assign mp  = mag_t'(ma) * mag_t'(mb);
  assign lim = mag_t'(1) << (WordWidth - 1);
  assign fit_n = n_s_r ? (n_r <= lim) : (n_r < lim);
  assign fit_d = d_s_r ? (d_r <= lim) : (d_r < lim);

  // Sequencer.
  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; mu_nxt = mu_r; cmd_nxt = cmd_r;
    ln_nxt = ln_r; ld_nxt = ld_r; rn_nxt = rn_r; rd_nxt = rd_r;
    n_nxt = n_r; d_nxt = d_r;
    ln_s_nxt = ln_s_r; ld_s_nxt = ld_s_r; rn_s_nxt = rn_s_r; rd_s_nxt = rd_s_r;
    n_s_nxt = n_s_r; d_s_nxt = d_s_r;
    ga_nxt = ga_r; gb_nxt = gb_r; g_nxt = g_r;
    lf_nxt = lf_r; rf_nxt = rf_r; t1_nxt = t1_r; t1_s_nxt = t1_s_r;
    eq_nxt = eq_r; err_nxt = err_r;
    rn_out_nxt = rn_out_r; rd_out_nxt = rd_out_r;
    dreq_c = '0;
    ma = '0; mb = '0;
    done = 1'b0;
    unique case (st_r)
      StIdle: begin
        if (start) begin
          cmd_nxt = cmd;
          ln_nxt = absw(lhs_num); ln_s_nxt = lhs_num[31];
          ld_nxt = absw(lhs_den); ld_s_nxt = lhs_den[31];
          rn_nxt = absw(rhs_num); rn_s_nxt = rhs_num[31];
          rd_nxt = absw(rhs_den); rd_s_nxt = rhs_den[31];
          eq_nxt = 1'b0; err_nxt = ErrNone;
          rn_out_nxt = 32'd0; rd_out_nxt = 32'd1;
          if (cmd > CmdCmp) begin
            st_nxt = StDone;
          end else if (lhs_den == 32'd0 || rhs_den == 32'd0) begin
            err_nxt = ErrZeroDen;
            st_nxt = StDone;
          end else begin
            ph_nxt = PhLeft;
            ga_nxt = absw(lhs_num); gb_nxt = absw(lhs_den);
            st_nxt = StGcdDiv;
          end
        end
      end
      // Euclid: ga mod gb until gb is zero.
      StGcdDiv: begin
        if (gb_r == '0) begin
          g_nxt = ga_r;
          if (ph_r == PhLcm) begin
            dreq_c.start = 1'b1;
            dreq_c.dividend = rd_r; dreq_c.divisor = ga_r;
            ph_nxt = PhLcmQ;
            st_nxt = StRedAWt;
          end else if (ga_r == '0) begin
            st_nxt = StRedB;
          end else begin
            dreq_c.start = 1'b1;
            dreq_c.dividend = (ph_r == PhLeft) ? ln_r : (ph_r == PhRight) ? rn_r : n_r;
            dreq_c.divisor = ga_r;
            st_nxt = StRedAWt;
          end
        end else begin
          dreq_c.start = 1'b1;
          dreq_c.dividend = ga_r; dreq_c.divisor = gb_r;
          st_nxt = StGcdWt;
        end
      end
      StGcdWt: begin
        if (drsp.done) begin
          ga_nxt = gb_r; gb_nxt = drsp.remainder;
          st_nxt = StGcdDiv;
        end
      end
      StRedAWt: begin
        if (drsp.done) begin
          priority case (ph_r)
            PhLeft:  ln_nxt = drsp.quotient;
            PhRight: rn_nxt = drsp.quotient;
            PhLcm, PhLcmQ: lf_nxt = drsp.quotient;
            default: n_nxt = drsp.quotient;
          endcase
          dreq_c.start = 1'b1;
          dreq_c.dividend = (ph_r == PhLeft) ? ld_r : (ph_r == PhRight) ? rd_r :
                            (ph_r == PhLcmQ) ? ld_r : d_r;
          dreq_c.divisor = g_r;
          st_nxt = StRedBWt;
        end
      end
      StRedBWt: begin
        if (drsp.done) begin
          priority case (ph_r)
            PhLeft:  ld_nxt = drsp.quotient;
            PhRight: rd_nxt = drsp.quotient;
            PhLcmQ:  rf_nxt = drsp.quotient;
            default: d_nxt = drsp.quotient;
          endcase
          st_nxt = StRedB;
        end
      end
      // After a reduce: clear sign of zero, pick next phase.
      StRedB: begin
        priority case (ph_r)
          PhLeft: begin
            if (ln_r == '0) ln_s_nxt = 1'b0;
            ph_nxt = PhRight;
            ga_nxt = rn_r; gb_nxt = rd_r;
            st_nxt = StGcdDiv;
          end
          PhRight: begin
            if (rn_r == '0) rn_s_nxt = 1'b0;
            mu_nxt = MuA;
            if (cmd_r == CmdCmp || cmd_r == CmdMul) begin
              st_nxt = StMul;
            end else if (cmd_r == CmdDiv && rn_r == '0) begin
              err_nxt = ErrDivZero;
              st_nxt = StDone;
            end else if (cmd_r == CmdDiv) begin
              st_nxt = StMul;
            end else begin
              ph_nxt = PhLcm;
              ga_nxt = ld_r; gb_nxt = rd_r;
              st_nxt = StGcdDiv;
            end
          end
          PhLcmQ: begin
            st_nxt = StMul;
          end
          default: begin
            if (n_r == '0) n_s_nxt = 1'b0;
            st_nxt = StFinish;
          end
        endcase
      end
      // At most one 32x32 product per cycle.
      StMul: begin
        priority case (cmd_r)
          CmdCmp: begin
            if (mu_r == MuA) begin
              ma = ln_r[31:0]; mb = rd_r[31:0];
              t1_nxt = mp; mu_nxt = MuB;
            end else begin
              ma = ld_r[31:0]; mb = rn_r[31:0];
              eq_nxt = (t1_r == mp) &&
                       ((t1_r == '0 ? 1'b0 : ln_s_r ^ rd_s_r) ==
                        (mp == '0 ? 1'b0 : ld_s_r ^ rn_s_r));
              st_nxt = StDone;
            end
          end
          CmdMul, CmdDiv: begin
            if (mu_r == MuA) begin
              ma = ln_r[31:0];
              mb = (cmd_r == CmdMul) ? rn_r[31:0] : rd_r[31:0];
              n_nxt = mp;
              n_s_nxt = ln_s_r ^ ((cmd_r == CmdMul) ? rn_s_r : rd_s_r);
              mu_nxt = MuB;
            end else begin
              ma = ld_r[31:0];
              mb = (cmd_r == CmdMul) ? rd_r[31:0] : rn_r[31:0];
              d_nxt = mp;
              d_s_nxt = ld_s_r ^ ((cmd_r == CmdMul) ? rd_s_r : rn_s_r);
              ph_nxt = PhRes;
              ga_nxt = n_r; gb_nxt = mp;
              st_nxt = StGcdDiv;
            end
          end
          default: begin
            unique case (mu_r)
              MuA: begin
                ma = ln_r[31:0]; mb = lf_r[31:0];
                t1_nxt = mp; t1_s_nxt = (mp == '0) ? 1'b0 : ln_s_r ^ ld_s_r;
                mu_nxt = MuB;
              end
              MuB: begin
                logic t2s;
                ma = rn_r[31:0]; mb = rf_r[31:0];
                t2s = (mp == '0) ? 1'b0 : (rn_s_r ^ rd_s_r ^ (cmd_r == CmdSub));
                if (t1_s_r == t2s) begin
                  n_nxt = t1_r + mp; n_s_nxt = t1_s_r;
                end else if (t1_r >= mp) begin
                  n_nxt = t1_r - mp; n_s_nxt = t1_s_r;
                end else begin
                  n_nxt = mp - t1_r; n_s_nxt = t2s;
                end
                mu_nxt = MuC;
              end
              MuC: begin
                if (n_r == '0) n_s_nxt = 1'b0;
                ma = rf_r[31:0]; mb = rd_r[31:0];
                d_nxt = mp; d_s_nxt = 1'b0;
                mu_nxt = MuD;
              end
              default: begin
                ph_nxt = PhRes;
                ga_nxt = n_r; gb_nxt = d_r;
                st_nxt = StGcdDiv;
              end
            endcase
          end
        endcase
      end
      StFinish: begin
        if (fit_n && fit_d) begin
          rn_out_nxt = enc(n_s_r, n_r);
          rd_out_nxt = enc(d_s_r, d_r);
        end else begin
          err_nxt = ErrOverflow;
        end
        st_nxt = StDone;
      end
      StDone: begin
        done = 1'b1;
        st_nxt = StIdle;
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
    end else begin
      st_r <= st_nxt;
    end
    ph_r <= ph_nxt; mu_r <= mu_nxt; cmd_r <= cmd_nxt;
    ln_r <= ln_nxt; ld_r <= ld_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt;
    n_r <= n_nxt; d_r <= d_nxt;
    ln_s_r <= ln_s_nxt; ld_s_r <= ld_s_nxt; rn_s_r <= rn_s_nxt; rd_s_r <= rd_s_nxt;
    n_s_r <= n_s_nxt; d_s_r <= d_s_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt; g_r <= g_nxt;
    lf_r <= lf_nxt; rf_r <= rf_nxt; t1_r <= t1_nxt; t1_s_r <= t1_s_nxt;
    eq_r <= eq_nxt; err_r <= err_nxt;
    rn_out_r <= rn_out_nxt; rd_out_r <= rd_out_nxt;
  end

  assign dreq    = dreq_c;
  assign res_num = rn_out_r;
  assign res_den = rd_out_r;
  assign equal   = eq_r;
  assign error   = err_r;

endmodule

`default_nettype wire

/* rtl/core/rational_arithmetic_unit.sv */
// Timing is data dependent: each Euclid step of a gcd and each reduction division
// runs on the shared divider; unused commands and zero denominators go from idle
// straight to the done state. Throughput: one word at a time; the input is not ready
// during a word. The result sits in an output register, and the next word is accepted
// while it waits. Reset is synchronous, active low, and clears control only.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, divide and compare two fractions with gcd reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // lhs_num, lhs_den, rhs_num, rhs_den
  input  wire logic [2:0]   in_tuser,   // cmd
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [71:0]       out_tdata   // res_num, res_den, equal, error, pad
);
  import rau_pkg::*;

  logic      busy_r, busy_nxt;
  logic      pend_r, pend_nxt;
  logic      ov_r, ov_nxt;
  logic [71:0] od_r, od_nxt;
  logic      start, done, eq;
  logic [31:0] rnum, rden;
  logic [1:0] err;
  div_req_t  dreq;
  div_rsp_t  drsp;

  assign in_tready = !busy_r;
  assign start = in_tvalid && in_tready;

  rau_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .cmd(in_tuser),
    .lhs_num(in_tdata[31:0]), .lhs_den(in_tdata[63:32]),
    .rhs_num(in_tdata[95:64]), .rhs_den(in_tdata[127:96]),
    .dreq(dreq), .drsp(drsp), .done(done),
    .res_num(rnum), .res_den(rden), .equal(eq), .error(err)
  );

  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Output register: the finished word waits here; busy until it is loaded.
  // A finished word that meets a full output register is held as pending.
  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = pend_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (out_tvalid && out_tready) ov_nxt = 1'b0;
    if (start) busy_nxt = 1'b1;
    if (done) pend_nxt = 1'b1;
    if ((done || pend_r) && (!ov_r || out_tready)) begin
      ov_nxt = 1'b1;
      od_nxt = {5'd0, err, eq, rden, rnum};
      busy_nxt = 1'b0;
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      ov_r <= ov_nxt;
    end
    od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

`default_nettype wire
